/* sv/lrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the line rasterizer with clip test
// Coordinate widths, request and pixel payloads, queue entry and register map.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 3;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MAX_X = 2'd1;
  localparam logic [1:0] REG_MIN_Y = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN =
    {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX =
    {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         inside_res;
    logic                         last_pixel;
  } out_item_t;

  // Classified request: a start carries the fully prepared line setup
  typedef struct packed {
    logic                         mode;
    logic                         steep;
    logic                         minor_down;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [COORD_BITS-1:0] minor_pos;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [DEC_BITS-1:0]   decision;
    logic signed [DEC_BITS-1:0]   inc_e;
    logic signed [DEC_BITS-1:0]   inc_ne;
  } entry_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_y;
  } window_t;

endpackage

/* sv/line_raster_with_clip_test_unit.sv */
// ----------------------------------------------------------------------------
// line_raster_with_clip_test_unit: midpoint line rasterizer with window test
// APB clip-window registers, request classifier, request queue, pixel stepper.
// ----------------------------------------------------------------------------
// Path: an accepted step request is written into the request queue, then the
// stepper loads its pixel into the output register that drives out_valid.
// Throughput: one request per cycle unless the queue is full; the stepper's add
// and compare on the active line pace one pixel per cycle, held by out_ready.
// Reset: clip window opens to the full coordinate range, no line is active,
// and the request queue and output register are empty.
module line_raster_with_clip_test_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lrc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lrc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lrc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lrc_pkg::out_item_t                  out_data
);

  localparam int C = lrc_pkg::COORD_BITS;
  localparam int W = lrc_pkg::APB_DATA_BITS;

  lrc_pkg::window_t window;
  lrc_pkg::entry_t  front_entry;
  lrc_pkg::entry_t  head;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  logic             cfg_write;
  logic [C-1:0]     rd_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window.min_x <= lrc_pkg::COORD_MIN;
      window.max_x <= lrc_pkg::COORD_MAX;
      window.min_y <= lrc_pkg::COORD_MIN;
      window.max_y <= lrc_pkg::COORD_MAX;
    end else if (cfg_write) begin
      case (paddr[3:2])
        lrc_pkg::REG_MIN_X: window.min_x <= pwdata[C-1:0];
        lrc_pkg::REG_MAX_X: window.max_x <= pwdata[C-1:0];
        lrc_pkg::REG_MIN_Y: window.min_y <= pwdata[C-1:0];
        lrc_pkg::REG_MAX_Y: window.max_y <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lrc_pkg::REG_MIN_X: rd_reg = window.min_x;
      lrc_pkg::REG_MAX_X: rd_reg = window.max_x;
      lrc_pkg::REG_MIN_Y: rd_reg = window.min_y;
      lrc_pkg::REG_MAX_Y: rd_reg = window.max_y;
      default:            rd_reg = window.min_x;
    endcase
    prdata = {{(W-C){rd_reg[C-1]}}, rd_reg};
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  lrc_front u_front (
    .item  (in_data),
    .entry (front_entry)
  );

  lrc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_entry),
    .full  (q_full),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty)
  );

  lrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* sv/lrc_front.sv */
// ----------------------------------------------------------------------------
// lrc_front: request classifier and line setup
// Turns start requests into major/minor axis setup; passes step requests on.
// ----------------------------------------------------------------------------
module lrc_front (
  input  lrc_pkg::in_item_t item,
  output lrc_pkg::entry_t   entry
);

  localparam int C = lrc_pkg::COORD_BITS;
  localparam int D = lrc_pkg::DEC_BITS;

  logic signed [C:0]   diff_x;
  logic signed [C:0]   diff_y;
  logic signed [C:0]   abs_x;
  logic signed [C:0]   abs_y;
  logic [C-1:0]        dx;
  logic [C-1:0]        dy;
  logic [C-1:0]        dmaj;
  logic [C-1:0]        dmin;
  logic                steep;
  logic signed [C-1:0] amaj;
  logic signed [C-1:0] amin;
  logic signed [C-1:0] bmaj;
  logic signed [C-1:0] bmin;
  logic                swap;
  logic signed [D-1:0] two_dmin;
  logic signed [D-1:0] two_dmaj;

  always_comb begin
    diff_x = {item.start_x[C-1], item.start_x} - {item.end_x[C-1], item.end_x};
    diff_y = {item.start_y[C-1], item.start_y} - {item.end_y[C-1], item.end_y};
    abs_x  = diff_x[C] ? -diff_x : diff_x;
    abs_y  = diff_y[C] ? -diff_y : diff_y;
    dx     = abs_x[C-1:0];
    dy     = abs_y[C-1:0];
    steep  = dy > dx;

    if (steep) begin
      amaj = item.start_y; amin = item.start_x;
      bmaj = item.end_y;   bmin = item.end_x;
      dmaj = dy;           dmin = dx;
    end else begin
      amaj = item.start_x; amin = item.start_y;
      bmaj = item.end_x;   bmin = item.end_y;
      dmaj = dx;           dmin = dy;
    end

    // order endpoints so the major coordinate increases
    swap     = amaj > bmaj;
    two_dmin = {2'b00, dmin, 1'b0};
    two_dmaj = {2'b00, dmaj, 1'b0};

    entry.mode       = item.mode;
    entry.steep      = steep;
    entry.major_pos  = swap ? bmaj : amaj;
    entry.minor_pos  = swap ? bmin : amin;
    entry.major_end  = swap ? amaj : bmaj;
    entry.minor_down = swap ? (bmin > amin) : (amin > bmin);
    entry.decision   = two_dmin - {3'b000, dmaj};
    entry.inc_e      = two_dmin;
    entry.inc_ne     = two_dmin - two_dmaj;
  end

endmodule

/* sv/lrc_queue.sv */
// ----------------------------------------------------------------------------
// lrc_queue: request queue between front and back
// Small FIFO of classified requests so either side can stall on its own.
// ----------------------------------------------------------------------------
module lrc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrc_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output lrc_pkg::entry_t rdata,
  output logic            empty
);

  localparam int P = lrc_pkg::QPTR_BITS;

  lrc_pkg::entry_t mem [lrc_pkg::QDEPTH];
  logic [P-1:0]    wr_ptr;
  logic [P-1:0]    rd_ptr;
  logic [P:0]      count;

  assign full  = count == (P+1)'(lrc_pkg::QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/lrc_back.sv */
// ----------------------------------------------------------------------------
// lrc_back: pixel stepper and clip test
// Holds the active line, emits one pixel per step request into an output register.
// ----------------------------------------------------------------------------
module lrc_back (
  input  logic               clk,
  input  logic               rst,
  input  lrc_pkg::window_t   window,
  input  lrc_pkg::entry_t    head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lrc_pkg::out_item_t out_data
);

  localparam int C = lrc_pkg::COORD_BITS;
  localparam int D = lrc_pkg::DEC_BITS;

  logic                busy;
  logic                steep;
  logic                minor_down;
  logic signed [C-1:0] major_pos;
  logic signed [C-1:0] minor_pos;
  logic signed [C-1:0] major_end;
  logic signed [D-1:0] decision;
  logic signed [D-1:0] inc_e;
  logic signed [D-1:0] inc_ne;

  logic                slot_free;
  logic                is_start;
  logic                emit;
  logic signed [C-1:0] px;
  logic signed [C-1:0] py;
  logic                in_window;
  logic                last;

  always_comb begin
    slot_free = !out_valid || out_ready;
    is_start  = head.mode == lrc_pkg::MODE_START;
    // a step with no active line is dropped without waiting for the output
    pop       = head_valid && (is_start || !busy || slot_free);
    emit      = head_valid && !is_start && busy && slot_free;
    px        = steep ? minor_pos : major_pos;
    py        = steep ? major_pos : minor_pos;
    in_window = (window.min_x <= px) && (px <= window.max_x) &&
                (window.min_y <= py) && (py <= window.max_y);
    last      = major_pos >= major_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      steep      <= 1'b0;
      minor_down <= 1'b0;
      major_pos  <= '0;
      minor_pos  <= '0;
      major_end  <= '0;
      decision   <= '0;
      inc_e      <= '0;
      inc_ne     <= '0;
    end else if (pop && is_start) begin
      busy       <= 1'b1;
      steep      <= head.steep;
      minor_down <= head.minor_down;
      major_pos  <= head.major_pos;
      minor_pos  <= head.minor_pos;
      major_end  <= head.major_end;
      decision   <= head.decision;
      inc_e      <= head.inc_e;
      inc_ne     <= head.inc_ne;
    end else if (emit) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        major_pos <= major_pos + 1'b1;
        if (decision <= 0) begin
          decision <= decision + inc_e;
        end else begin
          decision  <= decision + inc_ne;
          minor_pos <= minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.pixel_x    <= px;
      out_data.pixel_y    <= py;
      out_data.inside_res <= in_window;
      out_data.last_pixel <= last;
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> !busy)
    else $error("line still active after its last pixel");

  a_major_advances: assert property (@(posedge clk) disable iff (rst)
    (emit && !last) |=> (busy && major_pos == $past(major_pos) + 1'b1))
    else $error("major coordinate did not advance by one");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (pop && !is_start && !busy && slot_free) |=> !out_valid)
    else $error("step request with no active line produced a pixel");

  a_no_emit_unless_popped: assert property (@(posedge clk) disable iff (rst)
    emit |-> pop)
    else $error("pixel emitted without consuming its request");

endmodule
